// File: rtl/core/ubf_pkg.sv
// Package for the UART receive/transmit FIFO buffering: types, codes and defaults.
`default_nettype none
package ubf_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int BYTE_W        = 8;
   localparam int CMD_W         = 3;
   localparam int COUNT_W       = 32;

   localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HOST_WR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HOST_RD  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RX_FLUSH = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data;
      logic              parity_error;
      logic              frame_error;
      logic              overrun_seen;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_valid;
      logic               write_refused;
      logic               tx_request;
      logic               rx_available;
      logic [COUNT_W-1:0] drop_total;
      logic [COUNT_W-1:0] error_total;
   } rsp_type;

   // per-ring strobes, already qualified against full/empty by the caller
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

endpackage
`default_nettype wire

// File: rtl/core/ubf_ring.sv
// Ring FIFO: head/tail pointers around a synchronous byte memory with registered read.
`default_nettype none
module ubf_ring #(
   parameter int DEPTH = ubf_pkg::DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ubf_pkg::ring_ctrl_type    ctrl,
   input  wire logic [ubf_pkg::BYTE_W-1:0] wdata,
   output logic [ubf_pkg::BYTE_W-1:0]     rdata,
   output ubf_pkg::ring_stat_type         stat
);

   localparam int AW = $clog2(DEPTH);

   logic [ubf_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [ubf_pkg::BYTE_W-1:0] rdata_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] head_next;
   logic [AW-1:0] tail_next;

   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in = ctrl.push ? head_next : head_ff;
      priority if (ctrl.flush) begin
         tail_in = head_ff;
      end else if (ctrl.pop) begin
         tail_in = tail_next;
      end else begin
         tail_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[head_ff] <= wdata;
      end
      if (ctrl.pop) begin
         rdata_ff <= mem[tail_ff];
      end
   end

   assign rdata      = rdata_ff;
   assign stat.empty = (head_ff == tail_ff);
   assign stat.full  = (head_next == tail_ff);

   a_not_full_and_empty: assert property (@(posedge clock) disable iff (reset)
      !(stat.empty && stat.full))
      else $error("ring reports full and empty at once");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !stat.full)
      else $error("push into full ring");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.empty)
      else $error("pop from empty ring");

endmodule
`default_nettype wire

// File: rtl/core/uart_buffered_rx_tx_fifos_top.sv
// Top level: UART receive/transmit FIFO buffering with host command port.
`default_nettype none
// A request is taken whenever start is high and busy is low; busy stays low, so one
// request is taken every cycle. Its response appears in the following cycle on rsp_data,
// marked by rsp_strobe for exactly that cycle, and the receiver cannot stall it: the
// response is registered, as is the read port of the FIFO memories. Each FIFO holds
// DEPTH-1 bytes. Counters and flags in the response show the state after the request.
// No clearing pass is needed after reset.
module uart_buffered_rx_tx_fifos_top #(
   parameter int DEPTH = ubf_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ubf_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output ubf_pkg::rsp_type      rsp_data
);

   logic accept;
   ubf_pkg::ring_ctrl_type rx_ctrl, tx_ctrl;
   ubf_pkg::ring_stat_type rx_stat, tx_stat;
   logic [ubf_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

   logic [ubf_pkg::COUNT_W-1:0] drop_ff, drop_in;
   logic [ubf_pkg::COUNT_W-1:0] error_ff, error_in;
   logic irq_ff, irq_in;
   logic strobe_ff, strobe_in;
   logic rx_pop_ff, tx_pop_ff, refused_ff;
   logic refused_in;
   logic rx_good;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign rx_good = !req_data.parity_error && !req_data.frame_error;

   always_comb begin
      rx_ctrl    = '0;
      tx_ctrl    = '0;
      drop_in    = drop_ff;
      error_in   = error_ff;
      irq_in     = irq_ff;
      refused_in = 1'b0;
      if (accept) begin
         unique case (req_data.cmd)
            ubf_pkg::CMD_RX_BYTE: begin
               if (!rx_good) begin
                  error_in = error_ff + 1'b1;
               end else begin
                  // overrun and full-FIFO drop can both count in one request
                  drop_in = drop_ff + ubf_pkg::COUNT_W'(req_data.overrun_seen)
                            + ubf_pkg::COUNT_W'(rx_stat.full);
                  rx_ctrl.push = !rx_stat.full;
               end
            end
            ubf_pkg::CMD_TX_READY: begin
               tx_ctrl.pop = !tx_stat.empty;
               if (tx_stat.empty) begin
                  irq_in = 1'b0;
               end
            end
            ubf_pkg::CMD_HOST_WR: begin
               tx_ctrl.push = !tx_stat.full;
               refused_in   = tx_stat.full;
               if (!tx_stat.full) begin
                  irq_in = 1'b1;
               end
            end
            ubf_pkg::CMD_HOST_RD: begin
               rx_ctrl.pop = !rx_stat.empty;
            end
            ubf_pkg::CMD_RX_FLUSH: begin
               rx_ctrl.flush = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign strobe_in = accept;

   ubf_ring #(.DEPTH(DEPTH)) u_rx_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (rx_ctrl),
      .wdata (req_data.data),
      .rdata (rx_rdata),
      .stat  (rx_stat)
   );

   ubf_ring #(.DEPTH(DEPTH)) u_tx_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (tx_ctrl),
      .wdata (req_data.data),
      .rdata (tx_rdata),
      .stat  (tx_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff    <= '0;
         error_ff   <= '0;
         irq_ff     <= 1'b0;
         strobe_ff  <= 1'b0;
         rx_pop_ff  <= 1'b0;
         tx_pop_ff  <= 1'b0;
         refused_ff <= 1'b0;
      end else begin
         drop_ff    <= drop_in;
         error_ff   <= error_in;
         irq_ff     <= irq_in;
         strobe_ff  <= strobe_in;
         rx_pop_ff  <= rx_ctrl.pop;
         tx_pop_ff  <= tx_ctrl.pop;
         refused_ff <= refused_in;
      end
   end

   // state registers already hold the post-request values in the response cycle
   assign rsp_strobe             = strobe_ff;
   assign rsp_data.read_data     = rx_pop_ff ? rx_rdata : '0;
   assign rsp_data.tx_byte       = tx_pop_ff ? tx_rdata : '0;
   assign rsp_data.tx_valid      = tx_pop_ff;
   assign rsp_data.write_refused = refused_ff;
   assign rsp_data.tx_request    = irq_ff;
   assign rsp_data.rx_available  = !rx_stat.empty;
   assign rsp_data.drop_total    = drop_ff;
   assign rsp_data.error_total   = error_ff;

   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request taken without a response next cycle");

   a_single_pop: assert property (@(posedge clock) disable iff (reset)
      !(rx_pop_ff && tx_pop_ff))
      else $error("both FIFOs popped by one request");

   a_refused_no_push: assert property (@(posedge clock) disable iff (reset)
      refused_in |-> !tx_ctrl.push && irq_in == irq_ff)
      else $error("refused host write changed transmit state");

   a_irq_set_on_write: assert property (@(posedge clock) disable iff (reset)
      tx_ctrl.push |=> rsp_data.tx_request)
      else $error("transmit request not set after host write");

endmodule
`default_nettype wire

// File: tb/uart_buffered_rx_tx_fifos_checker.sv
// Checker for the UART FIFO buffering: predicts each response and compares it field by field.
`timescale 1ns / 1ps
module uart_buffered_rx_tx_fifos_checker #(
   parameter int DEPTH = ubf_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire ubf_pkg::req_type req_data,
   input  wire logic             rsp_strobe,
   input  wire ubf_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending
);

   // shadow copy of both rings and the counters
   logic [ubf_pkg::BYTE_W-1:0]  rx_ring [DEPTH];
   logic [ubf_pkg::BYTE_W-1:0]  tx_ring [DEPTH];
   int                          rx_wr, rx_rd, tx_wr, tx_rd;
   logic                        tx_req;
   logic [ubf_pkg::COUNT_W-1:0] drop_cnt, err_cnt;

   ubf_pkg::rsp_type buffer_status_q[$];
   ubf_pkg::rsp_type want;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int ring_next(int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   // applies one request to the shadow state, returns the status it should produce
   function automatic ubf_pkg::rsp_type predict_buffer_status(ubf_pkg::req_type r);
      ubf_pkg::rsp_type s;
      int               nxt;
      s = '0;
      case (r.cmd)
         ubf_pkg::CMD_RX_BYTE: begin
            if (r.parity_error || r.frame_error) begin
               err_cnt = err_cnt + 1'b1;
            end else begin
               if (r.overrun_seen) drop_cnt = drop_cnt + 1'b1;
               nxt = ring_next(rx_wr);
               if (nxt != rx_rd) begin
                  rx_ring[rx_wr] = r.data;
                  rx_wr = nxt;
               end else begin
                  drop_cnt = drop_cnt + 1'b1;
               end
            end
         end
         ubf_pkg::CMD_TX_READY: begin
            if (tx_wr != tx_rd) begin
               s.tx_byte  = tx_ring[tx_rd];
               s.tx_valid = 1'b1;
               tx_rd = ring_next(tx_rd);
            end else begin
               tx_req = 1'b0;
            end
         end
         ubf_pkg::CMD_HOST_WR: begin
            nxt = ring_next(tx_wr);
            if (nxt != tx_rd) begin
               tx_ring[tx_wr] = r.data;
               tx_wr  = nxt;
               tx_req = 1'b1;
            end else begin
               s.write_refused = 1'b1;
            end
         end
         ubf_pkg::CMD_HOST_RD: begin
            if (rx_wr != rx_rd) begin
               s.read_data = rx_ring[rx_rd];
               rx_rd = ring_next(rx_rd);
            end
         end
         ubf_pkg::CMD_RX_FLUSH: rx_rd = rx_wr;
         default: ;
      endcase
      s.tx_request   = tx_req;
      s.rx_available = (rx_wr != rx_rd);
      s.drop_total   = drop_cnt;
      s.error_total  = err_cnt;
      return s;
   endfunction

   task automatic check_field(input string name, input logic [ubf_pkg::COUNT_W-1:0] exp_val,
                              input logic [ubf_pkg::COUNT_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_wr    = 0;
         rx_rd    = 0;
         tx_wr    = 0;
         tx_rd    = 0;
         tx_req   = 1'b0;
         drop_cnt = '0;
         err_cnt  = '0;
         buffer_status_q.delete();
      end else begin
         // push before pop so a same-cycle response would still find its request
         if (start && !busy) buffer_status_q.push_back(predict_buffer_status(req_data));
         if (rsp_strobe !== 1'b0) begin
            if (buffer_status_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = buffer_status_q.pop_front();
               check_field("read_data", 32'(want.read_data), 32'(rsp_data.read_data));
               check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_data.tx_byte));
               check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_data.tx_valid));
               check_field("write_refused", 32'(want.write_refused),
                           32'(rsp_data.write_refused));
               check_field("tx_request", 32'(want.tx_request), 32'(rsp_data.tx_request));
               check_field("rx_available", 32'(want.rx_available),
                           32'(rsp_data.rx_available));
               check_field("drop_total", want.drop_total, rsp_data.drop_total);
               check_field("error_total", want.error_total, rsp_data.error_total);
            end
         end
      end
      pending = buffer_status_q.size();
   end

endmodule

// File: tb/uart_buffered_rx_tx_fifos_top_tb.sv
// Testbench top for the UART FIFO buffering: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module uart_buffered_rx_tx_fifos_top_tb;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_REQUESTS = 520;
   localparam int FILL_BURST_LEN  = 200;
   localparam int DRAIN_CYCLES    = 8;

   typedef enum int {BURST_FILL_RX, BURST_FILL_TX, BURST_DRAIN, BURST_MIXED} burst_kind_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   ubf_pkg::req_type req_data;
   logic             rsp_strobe;
   ubf_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               cycle_count = 0;

   always #2 clock = ~clock;

   uart_buffered_rx_tx_fifos_top #(.DEPTH(ubf_pkg::DEPTH_DEFAULT)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   uart_buffered_rx_tx_fifos_checker #(.DEPTH(ubf_pkg::DEPTH_DEFAULT)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic ubf_pkg::req_type make_req(input logic [ubf_pkg::CMD_W-1:0] cmd,
                                                 input logic [ubf_pkg::BYTE_W-1:0] data,
                                                 input logic par, input logic frm,
                                                 input logic ovr);
      ubf_pkg::req_type r;
      r.cmd          = cmd;
      r.data         = data;
      r.parity_error = par;
      r.frame_error  = frm;
      r.overrun_seen = ovr;
      return r;
   endfunction

   // fill bursts keep error flags rare so the rings actually reach full
   function automatic ubf_pkg::req_type random_request(input burst_kind_type kind);
      ubf_pkg::req_type r;
      int               roll;
      int unsigned      rnd;
      rnd            = $urandom_range(7);
      r.cmd          = rnd[ubf_pkg::CMD_W-1:0];
      rnd            = $urandom;
      r.data         = rnd[ubf_pkg::BYTE_W-1:0];
      r.parity_error = ($urandom_range(15) == 0);
      r.frame_error  = ($urandom_range(15) == 0);
      r.overrun_seen = ($urandom_range(7) == 0);
      roll = $urandom_range(99);
      case (kind)
         BURST_FILL_RX: if (roll < 85) r.cmd = ubf_pkg::CMD_RX_BYTE;
         BURST_FILL_TX: if (roll < 85) r.cmd = ubf_pkg::CMD_HOST_WR;
         BURST_DRAIN: begin
            if (roll < 45) r.cmd = ubf_pkg::CMD_TX_READY;
            else if (roll < 90) r.cmd = ubf_pkg::CMD_HOST_RD;
         end
         default: begin
            rnd            = $urandom;
            r.parity_error = rnd[0];
            r.frame_error  = rnd[1];
            r.overrun_seen = rnd[2];
         end
      endcase
      return r;
   endfunction

   // busy is read at the falling edge, where it holds the value the next rising edge sees
   task automatic send_request(input ubf_pkg::req_type r, input int idle_pct);
      logic took;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
   endtask

   initial begin : stimulus
      burst_kind_type kind;
      int             idle_pct;
      int             burst_len;
      int             issued;
      int             bursts;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // receive path: extremes, overrun, each error flag, errors masking overrun
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'hA5, 1'b0, 1'b0, 1'b1), 0);
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'h3C, 1'b1, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'hC3, 1'b0, 1'b1, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'hFF, 1'b1, 1'b1, 1'b1), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_RD, 8'hFF, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      // transmit path: ready while empty, writes, pops, then ready on empty clears request
      send_request(make_req(ubf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_WR, 8'hFF, 1'b1, 1'b1, 1'b1), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_WR, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      // flush drops pending receive bytes
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'h5A, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_RX_BYTE, 8'h96, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_RX_FLUSH, 8'hFF, 1'b0, 1'b0, 1'b0), 0);
      send_request(make_req(ubf_pkg::CMD_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0), 0);
      // unused command codes must leave state alone
      for (int c = ubf_pkg::CMD_RX_FLUSH + 1; c < (1 << ubf_pkg::CMD_W); c++)
         send_request(make_req(c[ubf_pkg::CMD_W-1:0], 8'hFF, 1'b1, 1'b1, 1'b1), 0);

      issued = 0;
      bursts = 0;
      while (issued < RANDOM_REQUESTS) begin
         case (bursts)
            0:       kind = BURST_FILL_RX;
            1:       kind = BURST_FILL_TX;
            default: kind = burst_kind_type'($urandom_range(3));
         endcase
         burst_len = (bursts < 2) ? FILL_BURST_LEN : $urandom_range(10, 80);
         case (bursts % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 78;
            default: idle_pct = 22;
         endcase
         repeat (burst_len) begin
            send_request(random_request(kind), idle_pct);
            issued++;
         end
         bursts++;
      end
      start <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/ubf_pkg.sv
rtl/core/ubf_ring.sv
rtl/core/uart_buffered_rx_tx_fifos_top.sv
tb/uart_buffered_rx_tx_fifos_checker.sv
tb/uart_buffered_rx_tx_fifos_top_tb.sv
